// ----- hdl/gms_pkg.sv -----
package gms_pkg;

    // fixed field widths
    localparam int unsigned SAMPLE_BITS     = 24;
    localparam int unsigned COUNT_BITS      = 9;
    localparam int unsigned MAX_SAMPLES_DEF = 256;

    // cells per group in the first level of the median select tree
    localparam int unsigned GRP_BITS = 4;
    localparam int unsigned GRP_SIZE = 1 << GRP_BITS;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef struct packed {
        t_sample sample;
        logic    last;
    } t_in;

    typedef struct packed {
        t_sample               median;
        logic [COUNT_BITS-1:0] group_count;
        logic                  overflow;
    } t_out;

    // group summary that travels alongside the median select
    typedef struct packed {
        logic [COUNT_BITS-1:0] group_count;
        logic                  overflow;
    } t_tag;

endpackage

// ----- hdl/gms_cell.sv -----
module gms_cell #(
    parameter int unsigned IDX   = 0,
    parameter int unsigned CNT_W = 9
) (
    input  logic                 i_clk,
    input  logic                 i_load,
    input  gms_pkg::t_sample     i_sample,
    input  logic [CNT_W-1:0]     i_fill,
    input  gms_pkg::t_sample     i_left_val,
    input  logic                 i_left_gt,
    output gms_pkg::t_sample     o_val,
    output logic                 o_gt
);

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    gms_pkg::t_sample r_val;
    gms_pkg::t_sample n_val;

    // an empty slot counts as larger than any sample
    assign o_gt = (MY_IDX >= i_fill) || (r_val > i_sample);

    // shift up from the left neighbor, or take the new sample at the insert point
    always_comb begin
        n_val = r_val;
        if (o_gt) begin
            n_val = i_left_gt ? i_left_val : i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_val <= n_val;
        end
    end

    assign o_val = r_val;

endmodule

// ----- hdl/gms_select.sv -----
module gms_select #(
    parameter int unsigned MAX_SAMPLES = gms_pkg::MAX_SAMPLES_DEF,
    parameter int unsigned IDX_W       = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gms_pkg::t_sample  i_cells [MAX_SAMPLES],
    input  logic              i_valid,
    input  logic [IDX_W-1:0]  i_mid,
    input  gms_pkg::t_tag     i_tag,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    output gms_pkg::t_out     o_data
);

    localparam int unsigned NGRP  = (MAX_SAMPLES + gms_pkg::GRP_SIZE - 1) / gms_pkg::GRP_SIZE;
    localparam int unsigned PAD   = NGRP * gms_pkg::GRP_SIZE;
    localparam int unsigned MID_W = $clog2(PAD);
    localparam int unsigned HI_W  = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int unsigned NGRPA = 1 << HI_W;

    gms_pkg::t_sample               w_pad [NGRP][gms_pkg::GRP_SIZE];
    logic [MID_W-1:0]               w_mid;
    logic [gms_pkg::GRP_BITS-1:0]   w_lo;
    logic [HI_W-1:0]                w_hi;

    gms_pkg::t_sample               r_grp [NGRPA];
    logic [HI_W-1:0]                r_hi;
    gms_pkg::t_tag                  r_a_tag;
    logic                           r_a_v;
    logic                           w_a_adv;

    gms_pkg::t_out                  r_out;
    logic                           r_o_v;

    // padded view of the cell row, unused tail reads as zero
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            for (int k = 0; k < gms_pkg::GRP_SIZE; k++) begin
                if (g * gms_pkg::GRP_SIZE + k < MAX_SAMPLES) begin
                    w_pad[g][k] = i_cells[g * gms_pkg::GRP_SIZE + k];
                end else begin
                    w_pad[g][k] = '0;
                end
            end
        end
    end

    assign w_mid = MID_W'(i_mid);
    assign w_lo  = w_mid[gms_pkg::GRP_BITS-1:0];
    assign w_hi  = HI_W'(w_mid >> gms_pkg::GRP_BITS);

    assign w_a_adv = r_a_v && (!r_o_v || i_ready);
    assign o_ready = !r_a_v || w_a_adv;

    // level one: pick the entry at the low index bits inside every group
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            for (int g = 0; g < NGRPA; g++) begin
                if (g < NGRP) begin
                    r_grp[g] <= w_pad[g][w_lo];
                end else begin
                    r_grp[g] <= '0;
                end
            end
            r_hi    <= w_hi;
            r_a_tag <= i_tag;
        end
    end

    // level two: pick the group, into the output register
    always_ff @(posedge i_clk) begin
        if (w_a_adv) begin
            r_out.median      <= r_grp[r_hi];
            r_out.group_count <= r_a_tag.group_count;
            r_out.overflow    <= r_a_tag.overflow;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            if (o_ready) begin
                r_a_v <= i_valid;
            end
            if (w_a_adv) begin
                r_o_v <= 1'b1;
            end else if (i_ready) begin
                r_o_v <= 1'b0;
            end
        end
    end

    assign o_valid = r_o_v;
    assign o_data  = r_out;

endmodule

// ----- hdl/group_median_select.sv -----
// channel | direction | handshake                 | beat payload
// --------+-----------+---------------------------+----------------------------------
// in      | input     | i_in_valid / o_in_ready   | t_in  {sample, last}
// out     | output    | o_out_valid / i_out_ready | t_out {median, group_count, overflow}
//
// One sample beat per cycle while o_in_ready is high: the row of cells
// compares every kept value to the broadcast sample and shifts larger values
// up by one in the same cycle. After the beat carrying last is taken, the
// result passes the pending register, group select and final select before
// o_out_valid rises; the next group's beats keep flowing meanwhile.
// Input stalls only while a finished result waits behind a stalled output.
// Reset (synchronous, active low) clears fill count, drop flag and valids;
// cell contents need no reset.
module group_median_select #(
    parameter int unsigned MAX_SAMPLES = gms_pkg::MAX_SAMPLES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  gms_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output gms_pkg::t_out  o_out_data
);

    localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int unsigned IDX_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SAMPLES);

    logic [CNT_W-1:0]   r_fill;
    logic [CNT_W-1:0]   n_fill;
    logic               r_drop;
    logic               w_acc;
    logic               w_has_room;
    logic               w_load;
    logic [31:0]        w_cnt_ext;

    logic               r_p_v;
    logic [IDX_W-1:0]   r_p_mid;
    gms_pkg::t_tag      r_p_tag;
    logic               w_sel_ready;
    logic               w_p_adv;

    gms_pkg::t_sample   w_cell_val [MAX_SAMPLES];
    logic               w_cell_gt  [MAX_SAMPLES];

    assign w_p_adv    = r_p_v && w_sel_ready;
    assign o_in_ready = !r_p_v || w_p_adv;
    assign w_acc      = i_in_valid && o_in_ready;
    assign w_has_room = r_fill < MAX_CNT;
    assign w_load     = w_acc && w_has_room;
    assign n_fill     = w_has_room ? r_fill + 1'b1 : r_fill;
    assign w_cnt_ext  = 32'(n_fill);

    // row of insertion cells
    for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
        if (i == 0) begin : g_first
            gms_cell #(.IDX(i), .CNT_W(CNT_W)) u_cell (
                .i_clk      (i_clk),
                .i_load     (w_load),
                .i_sample   (i_in_data.sample),
                .i_fill     (r_fill),
                .i_left_val (i_in_data.sample),
                .i_left_gt  (1'b0),
                .o_val      (w_cell_val[i]),
                .o_gt       (w_cell_gt[i])
            );
        end else begin : g_rest
            gms_cell #(.IDX(i), .CNT_W(CNT_W)) u_cell (
                .i_clk      (i_clk),
                .i_load     (w_load),
                .i_sample   (i_in_data.sample),
                .i_fill     (r_fill),
                .i_left_val (w_cell_val[i-1]),
                .i_left_gt  (w_cell_gt[i-1]),
                .o_val      (w_cell_val[i]),
                .o_gt       (w_cell_gt[i])
            );
        end
    end

    // group bookkeeping: fill count, drop flag, result pending
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_drop <= 1'b0;
            r_p_v  <= 1'b0;
        end else begin
            if (w_p_adv) begin
                r_p_v <= 1'b0;
            end
            if (w_acc) begin
                if (i_in_data.last) begin
                    r_fill <= '0;
                    r_drop <= 1'b0;
                    r_p_v  <= 1'b1;
                end else begin
                    r_fill <= n_fill;
                    r_drop <= r_drop || !w_has_room;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && i_in_data.last) begin
            r_p_mid             <= IDX_W'(n_fill >> 1);
            r_p_tag.group_count <= w_cnt_ext[gms_pkg::COUNT_BITS-1:0];
            r_p_tag.overflow    <= r_drop || !w_has_room;
        end
    end

    gms_select #(.MAX_SAMPLES(MAX_SAMPLES), .IDX_W(IDX_W)) u_select (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cells (w_cell_val),
        .i_valid (r_p_v),
        .i_mid   (r_p_mid),
        .i_tag   (r_p_tag),
        .o_ready (w_sel_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= MAX_CNT)
        else $error("fill count beyond capacity");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drop |-> (r_fill == MAX_CNT))
        else $error("drop flag set while store not full");

    a_group_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_in_data.last) |=> (r_fill == '0 && !r_drop && r_p_v))
        else $error("group not cleared after last beat");
`endif

endmodule
